### rtl/tms_pkg.sv
// Shared types, constants and note tables for the tone and melody sequencer.
package tms_pkg;

    localparam int MELODY_NOTES = 8;
    localparam int ROM_NOTES    = 8;
    localparam int PTR_W        = 4;
    localparam int ROM_IDX_W    = $clog2(ROM_NOTES);
    localparam int FREQ_W       = 16;
    localparam int DUR_W        = 16;
    localparam int GAP_W        = 8;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [GAP_W-1:0]  NOTE_GAP_RESET = GAP_W'(35);
    localparam logic [DUR_W-1:0]  ELAPSED_MAX    = '1;
    localparam logic [PTR_W-1:0]  MELODY_LAST    = PTR_W'(MELODY_NOTES);

    // Register index as taken from the word address bits of paddr.
    localparam logic REG_NOTE_GAP = 1'b0;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_PLAY   = 2'd1,
        REQ_STOP   = 2'd2,
        REQ_MELODY = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [FREQ_W-1:0]  freq_hz;
        logic [DUR_W-1:0]   duration_ms;
    } t_req_word;

    typedef struct packed {
        logic [FREQ_W-1:0]  tone_freq;
        logic               tone_on;
        logic               tone_started;
        logic               melody_running;
    } t_result_word;

    typedef logic [FREQ_W-1:0] t_freq_rom [ROM_NOTES];
    typedef logic [DUR_W-1:0]  t_len_rom  [ROM_NOTES];

    localparam t_freq_rom NOTE_FREQ_ROM = '{
        16'd523, 16'd659, 16'd784, 16'd1047, 16'd1319, 16'd1047, 16'd1319, 16'd1568
    };
    localparam t_len_rom NOTE_LEN_ROM = '{
        16'd75, 16'd75, 16'd75, 16'd90, 16'd90, 16'd85, 16'd90, 16'd240
    };

endpackage

### rtl/tone_and_melody_sequencer.sv
// Top level of the tone and melody sequencer: request register, tone state, result register.
//
// Buzzer tone sequencer. Each request word is a one-millisecond tick, a play
// request (frequency and duration), a stop, or a start of the eight-note
// startup melody; every request yields exactly one result word with the
// frequency being driven (0 when silent), a tone-on flag, a flag that this
// request started a new tone, and a melody-running flag. A tone ends on the
// tick where its elapsed count reaches its length; a zero duration sounds
// until the next tick. Playing with frequency 0 silences the buzzer, and any
// play or stop cancels the melody. Between melody notes the block waits
// note_gap_ms ticks (register 0, byte address 0, reset 35). Timing: a request
// word is taken into an input register, and when it advances the tone state
// and the result register update together, so the block sustains one word
// per cycle while the result register drains. The only thing that holds the
// input side back is a stalled, still-full result register. Write
// note_gap_ms only while no request is in flight.
module tone_and_melody_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  tms_pkg::t_req_word                   i_in_word,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output tms_pkg::t_result_word                o_out_word,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tms_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [tms_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tms_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    // configuration
    logic [tms_pkg::GAP_W-1:0]     r_note_gap;

    // request register
    logic                          r_in_valid;
    tms_pkg::t_req_word            r_in_word;

    // tone state
    logic                          r_sounding,   n_sounding;
    logic [tms_pkg::DUR_W-1:0]     r_elapsed,    n_elapsed;
    logic [tms_pkg::DUR_W-1:0]     r_tone_len,   n_tone_len;
    logic [tms_pkg::FREQ_W-1:0]    r_cur_freq,   n_cur_freq;
    logic                          r_melody_on,  n_melody_on;
    logic [tms_pkg::PTR_W-1:0]     r_note_ptr,   n_note_ptr;
    logic [tms_pkg::GAP_W-1:0]     r_gap_left,   n_gap_left;

    // result register
    logic                          r_out_valid;
    tms_pkg::t_result_word         r_out_word;
    logic                          n_started;

    logic                          advance;
    logic                          ended;
    logic                          do_step;
    logic [tms_pkg::ROM_IDX_W-1:0] rom_idx;

    // Move the held request into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // APB: no wait states, single register.
    assign pready = 1'b1;
    assign prdata = tms_pkg::APB_DATA_W'(r_note_gap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_gap <= tms_pkg::NOTE_GAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == tms_pkg::REG_NOTE_GAP)) begin
            r_note_gap <= pwdata[tms_pkg::GAP_W-1:0];
        end
    end

    // Tone state next value: the whole request is resolved in one pass.
    always_comb begin
        n_sounding  = r_sounding;
        n_elapsed   = r_elapsed;
        n_tone_len  = r_tone_len;
        n_cur_freq  = r_cur_freq;
        n_melody_on = r_melody_on;
        n_note_ptr  = r_note_ptr;
        n_gap_left  = r_gap_left;
        n_started   = 1'b0;
        ended       = 1'b0;
        do_step     = 1'b0;

        unique case (r_in_word.req_type)
            tms_pkg::REQ_TICK: begin
                if (r_sounding) begin
                    // saturate the elapsed count
                    if (r_elapsed != tms_pkg::ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (n_elapsed >= r_tone_len) begin
                        n_sounding = 1'b0;
                        n_cur_freq = '0;
                        ended      = 1'b1;
                        if (r_melody_on) begin
                            n_gap_left = r_note_gap;
                        end
                    end
                end
                if (!ended && (r_gap_left != '0)) begin
                    n_gap_left = r_gap_left - 1'b1;
                end
                do_step = r_melody_on && !n_sounding && (n_gap_left == '0);
            end
            tms_pkg::REQ_PLAY: begin
                n_melody_on = 1'b0;
                if (r_in_word.freq_hz == '0) begin
                    n_sounding = 1'b0;
                    n_cur_freq = '0;
                end else begin
                    n_sounding = 1'b1;
                    n_cur_freq = r_in_word.freq_hz;
                    n_elapsed  = '0;
                    n_tone_len = r_in_word.duration_ms;
                    n_started  = 1'b1;
                end
            end
            tms_pkg::REQ_STOP: begin
                n_melody_on = 1'b0;
                n_sounding  = 1'b0;
                n_cur_freq  = '0;
            end
            tms_pkg::REQ_MELODY: begin
                // restart from the first note with no gap
                n_melody_on = 1'b1;
                n_sounding  = 1'b0;
                n_cur_freq  = '0;
                n_note_ptr  = '0;
                n_gap_left  = '0;
                do_step     = 1'b1;
            end
        endcase

        // Melody step: end the melody after the last note, else start the next one.
        rom_idx = n_note_ptr[tms_pkg::ROM_IDX_W-1:0];
        if (do_step) begin
            if (n_note_ptr >= tms_pkg::MELODY_LAST) begin
                n_melody_on = 1'b0;
                n_note_ptr  = '0;
                n_sounding  = 1'b0;
                n_cur_freq  = '0;
            end else begin
                n_note_ptr = n_note_ptr + 1'b1;
                n_sounding = 1'b1;
                n_cur_freq = tms_pkg::NOTE_FREQ_ROM[rom_idx];
                n_elapsed  = '0;
                n_tone_len = tms_pkg::NOTE_LEN_ROM[rom_idx];
                n_started  = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sounding  <= 1'b0;
            r_elapsed   <= '0;
            r_tone_len  <= '0;
            r_cur_freq  <= '0;
            r_melody_on <= 1'b0;
            r_note_ptr  <= '0;
            r_gap_left  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_sounding  <= n_sounding;
                r_elapsed   <= n_elapsed;
                r_tone_len  <= n_tone_len;
                r_cur_freq  <= n_cur_freq;
                r_melody_on <= n_melody_on;
                r_note_ptr  <= n_note_ptr;
                r_gap_left  <= n_gap_left;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word.tone_freq      <= n_sounding ? n_cur_freq : '0;
            r_out_word.tone_on        <= n_sounding;
            r_out_word.tone_started   <= n_started;
            r_out_word.melody_running <= n_melody_on;
        end
    end

`ifndef SYNTHESIS
    a_silent_state_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sounding |-> (r_cur_freq == '0))
        else $error("tone state silent with nonzero frequency");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_note_ptr <= tms_pkg::MELODY_LAST)
        else $error("note pointer past melody end");

    a_started_implies_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_word.tone_started || r_out_word.tone_on))
        else $error("tone started flag without a sounding tone");

    a_silent_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.tone_on) |-> (r_out_word.tone_freq == '0))
        else $error("silent result carries a frequency");

    a_result_follows_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced request produced no result");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the tone and melody sequencer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Only the first few mismatches are printed; the rest are counted.
    localparam int MAX_REPORTS = 10;
    // Extra wait after the last status word has come back, with some margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 8;
    localparam logic [tms_pkg::GAP_W-1:0] GAP_AFTER_RESET = 8'd35;
    localparam logic [tms_pkg::APB_ADDR_W-1:0] NOTE_GAP_ADDR = {tms_pkg::REG_NOTE_GAP, 2'b00};

    logic clk;
    logic rst_n = 1'b0;

    // Request channel
    logic               req_valid = 1'b0;
    logic               req_stall;
    tms_pkg::t_req_word req_word = '0;

    // Result channel
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    tms_pkg::t_result_word res_word;

    // Configuration port
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [tms_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [tms_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [tms_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Idle rates in percent for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count = 0;
    int requests_sent = 0;
    int quiet_cycles = 0;

    // Buzzer status words predicted for accepted requests, oldest first
    tms_pkg::t_result_word pending_status[$];

    // Predicted sequencer state
    logic                       tone_sounding;
    logic [tms_pkg::DUR_W-1:0]  tone_elapsed;
    logic [tms_pkg::DUR_W-1:0]  tone_len;
    logic [tms_pkg::FREQ_W-1:0] tone_freq_q;
    logic                       melody_active;
    logic [tms_pkg::PTR_W-1:0]  note_idx;
    logic [tms_pkg::GAP_W-1:0]  gap_count;
    logic [tms_pkg::GAP_W-1:0]  note_gap_cfg;
    logic                       tone_started_q;

    tone_and_melody_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_word   (req_word),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_word  (res_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Tone prediction
    // ------------------------------------------------------------------

    // Startup melody: frequency and length of each of the eight notes.
    function automatic logic [tms_pkg::FREQ_W-1:0] melody_freq(logic [2:0] idx);
        case (idx)
            3'd0: return 16'd523;
            3'd1: return 16'd659;
            3'd2: return 16'd784;
            3'd3: return 16'd1047;
            3'd4: return 16'd1319;
            3'd5: return 16'd1047;
            3'd6: return 16'd1319;
            default: return 16'd1568;
        endcase
    endfunction

    function automatic logic [tms_pkg::DUR_W-1:0] melody_len(logic [2:0] idx);
        case (idx)
            3'd3, 3'd4, 3'd6: return 16'd90;
            3'd5: return 16'd85;
            3'd7: return 16'd240;
            default: return 16'd75;
        endcase
    endfunction

    function automatic void silence_tone();
        tone_sounding = 1'b0;
        tone_freq_q = '0;
    endfunction

    // A zero frequency silences instead of starting a tone.
    function automatic void start_tone(logic [tms_pkg::FREQ_W-1:0] freq,
                                       logic [tms_pkg::DUR_W-1:0] len);
        if (freq == '0) begin
            silence_tone();
        end else begin
            tone_sounding = 1'b1;
            tone_freq_q = freq;
            tone_elapsed = '0;
            tone_len = len;
            tone_started_q = 1'b1;
        end
    endfunction

    // Start the next note, or end the melody once every note has played.
    function automatic void next_melody_note();
        logic [2:0] rom_idx;
        if (note_idx >= tms_pkg::MELODY_NOTES) begin
            melody_active = 1'b0;
            note_idx = '0;
            silence_tone();
        end else begin
            // Indexes past the table wrap onto it.
            rom_idx = note_idx[2:0];
            note_idx = note_idx + 1'b1;
            start_tone(melody_freq(rom_idx), melody_len(rom_idx));
        end
    endfunction

    function automatic void reset_tone_state();
        tone_sounding = 1'b0;
        tone_elapsed = '0;
        tone_len = '0;
        tone_freq_q = '0;
        melody_active = 1'b0;
        note_idx = '0;
        gap_count = '0;
        note_gap_cfg = GAP_AFTER_RESET;
        tone_started_q = 1'b0;
    endfunction

    // Advance the predicted state by one request and return the status word it yields.
    function automatic tms_pkg::t_result_word next_buzzer_status(tms_pkg::t_req_word w);
        tms_pkg::t_result_word st;
        logic                  tone_ended;
        tone_started_q = 1'b0;
        tone_ended = 1'b0;
        case (w.req_type)
            tms_pkg::REQ_TICK: begin
                if (tone_sounding) begin
                    // Saturate the elapsed count.
                    if (tone_elapsed != tms_pkg::ELAPSED_MAX)
                        tone_elapsed = tone_elapsed + 1'b1;
                    if (tone_elapsed >= tone_len) begin
                        silence_tone();
                        tone_ended = 1'b1;
                        if (melody_active)
                            gap_count = note_gap_cfg;
                    end
                end
                // The gap only counts down on ticks where no tone ended.
                if (!tone_ended && gap_count != '0)
                    gap_count = gap_count - 1'b1;
                if (melody_active && !tone_sounding && gap_count == '0)
                    next_melody_note();
            end
            tms_pkg::REQ_PLAY: begin
                melody_active = 1'b0;
                start_tone(w.freq_hz, w.duration_ms);
            end
            tms_pkg::REQ_STOP: begin
                melody_active = 1'b0;
                silence_tone();
            end
            tms_pkg::REQ_MELODY: begin
                silence_tone();
                melody_active = 1'b1;
                note_idx = '0;
                gap_count = '0;
                next_melody_note();
            end
        endcase
        st.tone_freq = tone_sounding ? tone_freq_q : '0;
        st.tone_on = tone_sounding;
        st.tone_started = tone_started_q;
        st.melody_running = melody_active;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want !== got)
            log_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    // Check the word leaving the block first, then predict the one entering it.
    // Neither depends on the other in one edge: a word passes the input, then the result register.
    always @(posedge clk) begin
        tms_pkg::t_result_word want;
        if (!rst_n) begin
            reset_tone_state();
            pending_status.delete();
        end else begin
            if (res_valid && !res_stall) begin
                if (pending_status.size() == 0) begin
                    log_error($sformatf("status word with none pending: %p", res_word));
                end else begin
                    want = pending_status.pop_front();
                    compare_field("tone_freq", want.tone_freq, res_word.tone_freq);
                    compare_field("tone_on", want.tone_on, res_word.tone_on);
                    compare_field("tone_started", want.tone_started, res_word.tone_started);
                    compare_field("melody_running", want.melody_running,
                                  res_word.melody_running);
                end
            end
            if (req_valid && !req_stall)
                pending_status.push_back(next_buzzer_status(req_word));
        end
    end

    // Receiver back-pressure at the current rate.
    always @(negedge clk) begin
        res_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Declare the run hung when no word moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one request word, maybe after idle cycles, and hold it until taken.
    // Valid stays high afterwards so back-to-back words leave no bubble.
    task automatic send_request(tms_pkg::t_req_word w);
        @(negedge clk);
        // Idle each cycle at the sender's rate.
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do @(posedge clk); while (req_stall);
        requests_sent++;
    endtask

    // Fields that a request kind ignores get random content.
    function automatic tms_pkg::t_req_word random_request(tms_pkg::t_req_type kind);
        tms_pkg::t_req_word w;
        w.req_type = kind;
        w.freq_hz = tms_pkg::FREQ_W'($urandom);
        w.duration_ms = tms_pkg::DUR_W'($urandom);
        return w;
    endfunction

    task automatic send_fields(tms_pkg::t_req_type kind, logic [tms_pkg::FREQ_W-1:0] freq,
                               logic [tms_pkg::DUR_W-1:0] dur);
        tms_pkg::t_req_word w;
        w.req_type = kind;
        w.freq_hz = freq;
        w.duration_ms = dur;
        send_request(w);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_request(random_request(tms_pkg::REQ_TICK));
    endtask

    // Drop valid and hold off until every pending status word has come back.
    task automatic wait_until_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic check_note_gap_readback();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= NOTE_GAP_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        compare_field("note_gap_ms readback", note_gap_cfg, prdata[tms_pkg::GAP_W-1:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the note gap while the block is idle, then read it back.
    task automatic set_note_gap(logic [tms_pkg::GAP_W-1:0] gap);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NOTE_GAP_ADDR;
        pwdata <= tms_pkg::APB_DATA_W'(gap);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        note_gap_cfg = gap;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_note_gap_readback();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_reset();
        check_note_gap_readback();
    endtask

    // Field extremes, every request kind and the corner cases of the tone logic.
    task automatic test_directed_requests();
        send_fields(tms_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);   // tick with nothing sounding
        send_fields(tms_pkg::REQ_PLAY, 16'hFFFF, 16'h0000);   // zero duration: until next tick
        send_fields(tms_pkg::REQ_TICK, 16'h0000, 16'h0000);
        send_fields(tms_pkg::REQ_PLAY, 16'h5555, 16'hAAAA);
        send_fields(tms_pkg::REQ_PLAY, 16'hAAAA, 16'h5555);   // restart while sounding
        send_fields(tms_pkg::REQ_PLAY, 16'h0000, 16'hFFFF);   // zero frequency silences
        send_fields(tms_pkg::REQ_PLAY, 16'h0001, 16'h0002);
        send_ticks(2);                                        // ends on the second tick
        send_fields(tms_pkg::REQ_PLAY, 16'd100, 16'hFFFF);
        send_fields(tms_pkg::REQ_STOP, 16'hFFFF, 16'hFFFF);
        send_fields(tms_pkg::REQ_MELODY, 16'h0000, 16'h0000); // first note starts at once
        send_ticks(1);
        send_fields(tms_pkg::REQ_PLAY, 16'd440, 16'd3);       // play cancels the melody
        send_ticks(1);
        send_fields(tms_pkg::REQ_MELODY, 16'hFFFF, 16'hFFFF);
        send_fields(tms_pkg::REQ_MELODY, 16'h1234, 16'h4321); // restart while running
        send_fields(tms_pkg::REQ_STOP, 16'h0000, 16'h0000);   // stop cancels the melody
        send_fields(tms_pkg::REQ_MELODY, 16'h0000, 16'h0000);
        send_fields(tms_pkg::REQ_PLAY, 16'h0000, 16'h0000);   // silent play cancels too
        send_ticks(1);
        send_fields(tms_pkg::REQ_STOP, 16'h0000, 16'h0000);   // stop while idle
        send_ticks(2);
    endtask

    // Run the melody for a given number of ticks at one gap setting, then stop.
    task automatic test_full_melody(logic [tms_pkg::GAP_W-1:0] gap, int ticks);
        wait_until_idle();
        set_note_gap(gap);
        send_request(random_request(tms_pkg::REQ_MELODY));
        send_ticks(ticks);
        send_request(random_request(tms_pkg::REQ_STOP));
    endtask

    // Mostly melodies and short tones with random content, some noise in between.
    task automatic test_random_traffic(int count, int send_pct, int recv_pct,
                                       logic [tms_pkg::GAP_W-1:0] gap);
        int                 stop_at;
        int                 pick;
        int                 n;
        tms_pkg::t_req_word w;
        wait_until_idle();
        set_note_gap(gap);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Tick runs of 10 to 200, the longer ones crossing note changes, cut to the word budget.
                send_request(random_request(tms_pkg::REQ_MELODY));
                n = $urandom_range(10, 200);
                if (n > stop_at - requests_sent)
                    n = stop_at - requests_sent;
                repeat (n) begin
                    if ($urandom_range(0, 99) == 0)
                        send_request(random_request(
                            tms_pkg::t_req_type'($urandom_range(0, 3))));
                    else
                        send_request(random_request(tms_pkg::REQ_TICK));
                end
            end else if (pick < 85) begin
                w = random_request(tms_pkg::REQ_PLAY);
                if ($urandom_range(0, 9) == 0)
                    w.freq_hz = '0;
                if ($urandom_range(0, 99) < 70)
                    w.duration_ms = tms_pkg::DUR_W'($urandom_range(0, 20));
                send_request(w);
                send_ticks($urandom_range(0, 30));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_request(random_request(tms_pkg::t_req_type'($urandom_range(0, 3))));
            end
            // Now and then hold off until the block has drained.
            if ($urandom_range(0, 99) < 4)
                wait_until_idle();
        end
    endtask

    initial begin
        // Synchronous reset; release it away from the clock edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 64;
        test_register_reset();
        test_directed_requests();
        // Notes back to back, then the widest gap across one note change.
        test_full_melody(8'd0, 830);
        test_full_melody(8'd255, 340);

        test_random_traffic(117, 7, 64, 8'd3);
        test_random_traffic(117, 64, 7, tms_pkg::GAP_W'($urandom_range(0, 255)));
        test_random_traffic(117, 0, 0, 8'd1);

        wait_until_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/tms_pkg.sv
rtl/tone_and_melody_sequencer.sv
tb/sv/testbench.sv
